// ===== hdl/ftws_pkg.sv =====
// ----------------------------------------------------------------------------
// ftws_pkg: shared types and constants of the frame time window statistics
// Holds widths, register reset values, the sequencer states and the control
// structs that the top level broadcasts to the window and sort cell rows.
// ----------------------------------------------------------------------------
package ftws_pkg;

	// Window geometry.
	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;

	// Field widths.
	localparam int FT_W   = 34;
	localparam int TS_W   = 48;
	localparam int SPAN_W = 24;
	localparam int FPS_W  = 27;
	localparam int PID_W  = 23;
	localparam int SUM_W  = FT_W + IDX_W;
	localparam int DVD_W  = 46;
	localparam int DVS_W  = SUM_W + 1;
	localparam int REG_W  = 34;
	localparam int RIX_W  = 3;

	// Register indexes.
	localparam logic [RIX_W-1:0] REG_WINDOW_SPAN = 3'd0;
	localparam logic [RIX_W-1:0] REG_FRAME_CAP   = 3'd1;
	localparam logic [RIX_W-1:0] REG_INTERVAL    = 3'd2;
	localparam logic [RIX_W-1:0] REG_FRAME_LIMIT = 3'd3;
	localparam logic [RIX_W-1:0] REG_PID         = 3'd4;

	// Register reset values.
	localparam logic [SPAN_W-1:0] RST_WINDOW_SPAN = 24'd2000000;
	localparam logic [CNT_W-1:0]  RST_FRAME_CAP   = 9'd256;
	localparam logic [SPAN_W-1:0] RST_INTERVAL    = 24'd500000;
	localparam logic [FT_W-1:0]   RST_FRAME_LIMIT = 34'd10000000000;

	// Average fps arithmetic: twice 1e11, and the saturation level.
	localparam logic [37:0]      FPS_NUM2 = 38'd200000000000;
	localparam logic [DVD_W-1:0] FPS_MAX  = 46'd100000000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_EVICT,
		ST_GATHER,
		ST_MED,
		ST_THR,
		ST_SPIKE,
		ST_OUT
	} state_t;

	// Window cell operations.
	typedef enum logic [1:0] {
		WOP_HOLD,
		WOP_WRITE,
		WOP_SHIFT,
		WOP_ROT
	} win_op_t;

	// Sort cell operations.
	typedef enum logic [1:0] {
		SOP_HOLD,
		SOP_CLEAR,
		SOP_INSERT,
		SOP_ROT
	} sort_op_t;

	typedef struct packed {
		win_op_t          op;
		logic [IDX_W-1:0] idx;
		logic [FT_W-1:0]  frame;
		logic [TS_W-1:0]  tstamp;
	} win_ctl_t;

	typedef struct packed {
		sort_op_t         op;
		logic [IDX_W-1:0] idx;
		logic [FT_W-1:0]  x;
	} sort_ctl_t;

endpackage

// ===== hdl/ftws_win_cell.sv =====
// ----------------------------------------------------------------------------
// ftws_win_cell: one slot of the frame window
// Holds a frame time and its timestamp. Cell 0 is always the oldest frame;
// eviction shifts the row toward cell 0, a rotation walks it for readout.
// ----------------------------------------------------------------------------
module ftws_win_cell (
	input  logic                                clk,
	input  ftws_pkg::win_ctl_t                  ctl,
	input  logic [ftws_pkg::IDX_W-1:0]          my_idx,
	input  logic [ftws_pkg::FT_W-1:0]           nxt_frame,
	input  logic [ftws_pkg::TS_W-1:0]           nxt_tstamp,
	input  logic [ftws_pkg::FT_W-1:0]           head_frame,
	input  logic [ftws_pkg::TS_W-1:0]           head_tstamp,
	output logic [ftws_pkg::FT_W-1:0]           frame,
	output logic [ftws_pkg::TS_W-1:0]           tstamp
);
	import ftws_pkg::*;

	logic [FT_W-1:0] frame_q;
	logic [TS_W-1:0] tstamp_q;

	// Slot update: write at the tail, shift from the neighbor, or wrap the head.
	always_ff @(posedge clk) begin
		case (ctl.op)
			WOP_WRITE: begin
				if (my_idx == ctl.idx) begin
					frame_q  <= ctl.frame;
					tstamp_q <= ctl.tstamp;
				end
			end
			WOP_SHIFT: begin
				frame_q  <= nxt_frame;
				tstamp_q <= nxt_tstamp;
			end
			WOP_ROT: begin
				if (my_idx == ctl.idx) begin
					frame_q  <= head_frame;
					tstamp_q <= head_tstamp;
				end else begin
					frame_q  <= nxt_frame;
					tstamp_q <= nxt_tstamp;
				end
			end
			default: begin
			end
		endcase
	end

	assign frame  = frame_q;
	assign tstamp = tstamp_q;

endmodule

// ===== hdl/ftws_sort_cell.sv =====
// ----------------------------------------------------------------------------
// ftws_sort_cell: one cell of the systolic insertion sorter
// The row keeps its values in ascending order. An inserted value lands at
// once: larger values step one cell up. Empty cells act as infinity.
// ----------------------------------------------------------------------------
module ftws_sort_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ftws_pkg::sort_ctl_t         ctl,
	input  logic [ftws_pkg::IDX_W-1:0]  my_idx,
	input  logic [ftws_pkg::FT_W-1:0]   prev_val,
	input  logic                        prev_vld,
	input  logic [ftws_pkg::FT_W-1:0]   nxt_val,
	input  logic [ftws_pkg::FT_W-1:0]   head_val,
	output logic [ftws_pkg::FT_W-1:0]   val,
	output logic                        vld
);
	import ftws_pkg::*;

	logic [FT_W-1:0] val_q;
	logic            vld_q;
	logic            keep;
	logic            take_x;

	// Insert decision: keep own value, take the new one, or take the lower one.
	always_comb begin
		keep   = vld_q && (val_q <= ctl.x);
		take_x = (my_idx == '0) || (prev_vld && (prev_val <= ctl.x));
	end

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (ctl.op)
				SOP_CLEAR: vld_q <= 1'b0;
				SOP_INSERT: begin
					if (!keep) begin
						vld_q <= take_x ? 1'b1 : prev_vld;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Value.
	always_ff @(posedge clk) begin
		case (ctl.op)
			SOP_INSERT: begin
				if (!keep) begin
					val_q <= take_x ? ctl.x : prev_val;
				end
			end
			SOP_ROT: begin
				val_q <= (my_idx == ctl.idx) ? head_val : nxt_val;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

// ===== hdl/ftws_div.sv =====
// ----------------------------------------------------------------------------
// ftws_div: serial restoring divider
// Produces one quotient bit per cycle, most significant first, and holds
// the quotient once busy falls.
// ----------------------------------------------------------------------------
module ftws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ftws_pkg::DVD_W-1:0]  dividend,
	input  logic [ftws_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic [ftws_pkg::DVD_W-1:0]  quot
);
	import ftws_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quot_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	// Trial subtraction of one step. The remainder stays below the divisor,
	// so a trial that does not fit also fits the remainder register.
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			quot_q <= {quot_q[DVD_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// ===== hdl/frame_time_window_stats_core.sv =====
// ----------------------------------------------------------------------------
// frame_time_window_stats_core: sliding window frame time statistics
// Keeps a window of recent frames in a row of cells and, when the report
// interval has passed, reports span, count, average fps, p95, worst frame
// and spike count over the window.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    frame_time_ns, timestamp_us
// out      source     out_valid/out_ready  report_time_us .. process_id
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A dropped frame returns straight to idle. A kept frame passes the push state,
// with an extra push step when the window is full, then the evict state, which
// shifts out frames while eviction is due; a report then walks the window once
// to gather and the sort row twice, and waits for the serial fps divider.
// One item is in work at a time.
// Reset clears all control state; the window store needs no clearing pass.
// A stalled result holds in the output register while new items are taken;
// only the next report waits for it.
// ----------------------------------------------------------------------------
module frame_time_window_stats_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ftws_pkg::RIX_W-1:0]          cfg_index,
	input  logic [ftws_pkg::REG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ftws_pkg::FT_W-1:0]           frame_time_ns,
	input  logic [ftws_pkg::TS_W-1:0]           timestamp_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ftws_pkg::TS_W-1:0]           report_time_us,
	output logic [ftws_pkg::SPAN_W-1:0]         window_span_us_res,
	output logic [ftws_pkg::CNT_W-1:0]          window_frames,
	output logic [ftws_pkg::FPS_W-1:0]          avg_fps_x100,
	output logic [ftws_pkg::FT_W-1:0]           p95_frame_ns,
	output logic [ftws_pkg::FT_W-1:0]           last_frame_ns,
	output logic [ftws_pkg::FT_W-1:0]           worst_frame_ns,
	output logic [ftws_pkg::CNT_W-1:0]          spike_frames,
	output logic [ftws_pkg::PID_W-1:0]          process_id
);
	import ftws_pkg::*;

	localparam int PCT_W = 15;

	// Configuration registers.
	logic [SPAN_W-1:0] span_cfg_q;
	logic [CNT_W-1:0]  cap_cfg_q;
	logic [SPAN_W-1:0] intv_cfg_q;
	logic [FT_W-1:0]   limit_cfg_q;
	logic [PID_W-1:0]  pid_cfg_q;

	// Control state.
	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [TS_W-1:0]  last_rep_q;
	logic [CNT_W-1:0] k_q;
	logic             out_valid_q;

	// Item and report payload.
	logic [FT_W-1:0]   ft_q;
	logic [TS_W-1:0]   ts_q;
	logic [FT_W-1:0]   newest_frame_q;
	logic [TS_W-1:0]   newest_time_q;
	logic [CNT_W-1:0]  n_q;
	logic [PCT_W-1:0]  acc_q;
	logic [PCT_W-1:0]  tgt_q;
	logic [FT_W-1:0]   worst_q;
	logic [FT_W-1:0]   p95_q;
	logic [FT_W-1:0]   a_q;
	logic [FT_W-1:0]   b_q;
	logic [FT_W+2:0]   thr_q;
	logic [CNT_W-1:0]  spikes_q;
	logic [DVD_W-1:0]  prod_q;
	logic [SPAN_W-1:0] span_q;

	// Output registers.
	logic [TS_W-1:0]   o_time_q;
	logic [SPAN_W-1:0] o_span_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic [FPS_W-1:0]  o_fps_q;
	logic [FT_W-1:0]   o_p95_q;
	logic [FT_W-1:0]   o_last_q;
	logic [FT_W-1:0]   o_worst_q;
	logic [CNT_W-1:0]  o_spk_q;
	logic [PID_W-1:0]  o_pid_q;

	// Cell rows.
	win_ctl_t        win_ctl;
	sort_ctl_t       sort_ctl;
	logic [FT_W-1:0] win_frame [DEPTH];
	logic [TS_W-1:0] win_tstamp [DEPTH];
	logic [FT_W-1:0] srt_val [DEPTH];
	logic            srt_vld [DEPTH];

	// Divider.
	logic             div_start;
	logic             div_busy;
	logic [DVD_W-1:0] div_quot;
	logic [DVD_W-1:0] fps_sat;

	// Decisions.
	logic             in_acc;
	logic             keep_frame;
	logic [CNT_W-1:0] cap_eff;
	logic [TS_W-1:0]  span_ext;
	logic             age_out;
	logic             evict_now;
	logic             rep_go;
	logic             full;
	logic             last_step;
	logic             out_load;
	logic [CNT_W-1:0] idx_a;
	logic [CNT_W-1:0] idx_b;
	logic [TS_W-1:0]  span_diff;
	logic [FT_W:0]    ab_sum;

	assign cfg_ready = 1'b1;

	// Window and sort rows: cell 0 is the oldest frame and the smallest value.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cells
		logic [FT_W-1:0] nf;
		logic [TS_W-1:0] nt;
		logic [FT_W-1:0] sn;
		logic [FT_W-1:0] pv;
		logic            pl;
		if (i == DEPTH - 1) begin : g_last
			assign nf = '0;
			assign nt = '0;
			assign sn = '0;
		end else begin : g_mid
			assign nf = win_frame[i+1];
			assign nt = win_tstamp[i+1];
			assign sn = srt_val[i+1];
		end
		if (i == 0) begin : g_first
			assign pv = '0;
			assign pl = 1'b0;
		end else begin : g_rest
			assign pv = srt_val[i-1];
			assign pl = srt_vld[i-1];
		end
		ftws_win_cell u_win (
			.clk         (clk),
			.ctl         (win_ctl),
			.my_idx      (IDX_W'(i)),
			.nxt_frame   (nf),
			.nxt_tstamp  (nt),
			.head_frame  (win_frame[0]),
			.head_tstamp (win_tstamp[0]),
			.frame       (win_frame[i]),
			.tstamp      (win_tstamp[i])
		);
		ftws_sort_cell u_srt (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (sort_ctl),
			.my_idx   (IDX_W'(i)),
			.prev_val (pv),
			.prev_vld (pl),
			.nxt_val  (sn),
			.head_val (srt_val[0]),
			.val      (srt_val[i]),
			.vld      (srt_vld[i])
		);
	end

	ftws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q + DVD_W'(sum_q)),
		.divisor  ({sum_q, 1'b0}),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// Window decisions.
	always_comb begin
		in_acc     = in_valid && in_ready;
		keep_frame = (frame_time_ns != '0) && (frame_time_ns <= limit_cfg_q);
		if (cap_cfg_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_cfg_q > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap_cfg_q;
		end
		span_ext  = TS_W'(span_cfg_q);
		age_out   = (ts_q >= span_ext) && (win_tstamp[0] < (ts_q - span_ext));
		evict_now = (cnt_q != '0) && ((cnt_q > cap_eff) || age_out);
		rep_go    = (ts_q >= last_rep_q) && ((ts_q - last_rep_q) >= TS_W'(intv_cfg_q));
		full      = cnt_q == CNT_W'(DEPTH);
		last_step = k_q == (n_q - 1'b1);
		out_load  = (state_q == ST_OUT) && !div_busy && (!out_valid_q || out_ready);
		idx_b     = n_q >> 1;
		idx_a     = n_q[0] ? idx_b : (idx_b - 1'b1);
		span_diff = newest_time_q - win_tstamp[0];
		ab_sum    = {1'b0, a_q} + {1'b0, b_q};
		fps_sat   = (div_quot > FPS_MAX) ? FPS_MAX : div_quot;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc && keep_frame) state_nxt = ST_PUSH;
			ST_PUSH:   if (!full) state_nxt = ST_EVICT;
			ST_EVICT: begin
				if (!evict_now) begin
					state_nxt = (rep_go && cnt_q != '0) ? ST_GATHER : ST_IDLE;
				end
			end
			ST_GATHER: if (last_step) state_nxt = ST_MED;
			ST_MED:    if (last_step) state_nxt = ST_THR;
			ST_THR:    state_nxt = ST_SPIKE;
			ST_SPIKE:  if (last_step) state_nxt = ST_OUT;
			ST_OUT:    if (out_load) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: cell row commands and handshakes.
	always_comb begin
		in_ready        = state_q == ST_IDLE;
		div_start       = (state_q == ST_GATHER) && (k_q == '0);
		win_ctl.op      = WOP_HOLD;
		win_ctl.idx     = IDX_W'(n_q - 1'b1);
		win_ctl.frame   = ft_q;
		win_ctl.tstamp  = ts_q;
		sort_ctl.op     = SOP_HOLD;
		sort_ctl.idx    = IDX_W'(n_q - 1'b1);
		sort_ctl.x      = win_frame[0];
		case (state_q)
			ST_PUSH: begin
				if (full) begin
					win_ctl.op = WOP_SHIFT;
				end else begin
					win_ctl.op  = WOP_WRITE;
					win_ctl.idx = cnt_q[IDX_W-1:0];
				end
			end
			ST_EVICT: begin
				sort_ctl.op = SOP_CLEAR;
				if (evict_now) begin
					win_ctl.op = WOP_SHIFT;
				end
			end
			ST_GATHER: begin
				win_ctl.op  = WOP_ROT;
				sort_ctl.op = SOP_INSERT;
			end
			ST_MED:   sort_ctl.op = SOP_ROT;
			ST_SPIKE: sort_ctl.op = SOP_ROT;
			default: begin
			end
		endcase
	end

	// Configuration registers and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_cfg_q  <= RST_WINDOW_SPAN;
			cap_cfg_q   <= RST_FRAME_CAP;
			intv_cfg_q  <= RST_INTERVAL;
			limit_cfg_q <= RST_FRAME_LIMIT;
			pid_cfg_q   <= '0;
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			last_rep_q  <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_SPAN: span_cfg_q  <= cfg_data[SPAN_W-1:0];
					REG_FRAME_CAP:   cap_cfg_q   <= cfg_data[CNT_W-1:0];
					REG_INTERVAL:    intv_cfg_q  <= cfg_data[SPAN_W-1:0];
					REG_FRAME_LIMIT: limit_cfg_q <= cfg_data[FT_W-1:0];
					REG_PID:         pid_cfg_q   <= cfg_data[PID_W-1:0];
					default: begin
					end
				endcase
			end
			state_q <= state_nxt;
			case (state_q)
				ST_PUSH: begin
					if (full) begin
						cnt_q <= cnt_q - 1'b1;
						sum_q <= sum_q - SUM_W'(win_frame[0]);
					end else begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + SUM_W'(ft_q);
					end
				end
				ST_EVICT: begin
					k_q <= '0;
					if (evict_now) begin
						cnt_q <= cnt_q - 1'b1;
						sum_q <= sum_q - SUM_W'(win_frame[0]);
					end else if (rep_go) begin
						last_rep_q <= ts_q;
					end
				end
				ST_GATHER, ST_MED, ST_SPIKE: begin
					k_q <= last_step ? '0 : (k_q + 1'b1);
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and report datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ft_q <= frame_time_ns;
			ts_q <= timestamp_us;
		end
		case (state_q)
			ST_PUSH: begin
				if (!full) begin
					newest_frame_q <= ft_q;
					newest_time_q  <= ts_q;
				end
			end
			ST_EVICT: begin
				n_q     <= cnt_q;
				prod_q  <= DVD_W'(FPS_NUM2) * DVD_W'(cnt_q);
				tgt_q   <= PCT_W'(95 * (cnt_q - 1'b1) + 50);
				worst_q <= '0;
				acc_q   <= '0;
				if (newest_time_q < win_tstamp[0]) begin
					span_q <= '0;
				end else if (span_diff > TS_W'({SPAN_W{1'b1}})) begin
					span_q <= '1;
				end else begin
					span_q <= span_diff[SPAN_W-1:0];
				end
			end
			ST_GATHER: begin
				if (win_frame[0] > worst_q) begin
					worst_q <= win_frame[0];
				end
			end
			ST_MED: begin
				acc_q <= acc_q + PCT_W'(100);
				if ((acc_q <= tgt_q) && (tgt_q < (acc_q + PCT_W'(100)))) begin
					p95_q <= srt_val[0];
				end
				if (k_q == idx_a) a_q <= srt_val[0];
				if (k_q == idx_b) b_q <= srt_val[0];
			end
			ST_THR: begin
				thr_q    <= {ab_sum, 1'b0} + (FT_W+3)'(ab_sum);
				spikes_q <= '0;
			end
			ST_SPIKE: begin
				if ((FT_W+3)'({srt_val[0], 2'b00}) > thr_q) begin
					spikes_q <= spikes_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			o_time_q  <= ts_q;
			o_span_q  <= span_q;
			o_cnt_q   <= n_q;
			o_fps_q   <= fps_sat[FPS_W-1:0];
			o_p95_q   <= p95_q;
			o_last_q  <= newest_frame_q;
			o_worst_q <= worst_q;
			o_spk_q   <= spikes_q;
			o_pid_q   <= pid_cfg_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign report_time_us     = o_time_q;
	assign window_span_us_res = o_span_q;
	assign window_frames      = o_cnt_q;
	assign avg_fps_x100       = o_fps_q;
	assign p95_frame_ns       = o_p95_q;
	assign last_frame_ns      = o_last_q;
	assign worst_frame_ns     = o_worst_q;
	assign spike_frames       = o_spk_q;
	assign process_id         = o_pid_q;

	// The window never holds more frames than the row has cells.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("window count above depth");

	// A report walk never starts over an empty window.
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATHER) |-> (n_q != '0))
		else $error("report walk over empty window");

	// The divider is free whenever a new report starts it.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// A report is loaded only from the final state and leaves valid set.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("report load did not raise valid");

endmodule
